// ----- hdl/bmp_pixel_stream_decoder_assert.svh -----
// Assertion macros for the BMP pixel stream decoder checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef BMP_PIXEL_STREAM_DECODER_ASSERT_SVH
`define BMP_PIXEL_STREAM_DECODER_ASSERT_SVH

// Implication checked at every rising edge outside of reset.
`define BPSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- hdl/bmp_psd_pkg.sv -----
// Shared constants and types of the BMP pixel stream decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bmp_psd_pkg;
  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int MAX_HEIGHT_DEF    = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam logic [15:0] BMP_MAGIC = 16'h4D42;

  typedef logic [1:0] status_t;
  localparam status_t ST_PIXEL     = 2'd0;
  localparam status_t ST_BAD_MAGIC = 2'd1;
  localparam status_t ST_BAD_COMP  = 2'd2;
  localparam status_t ST_TOO_LARGE = 2'd3;

  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;
endpackage
`default_nettype wire

// ----- hdl/bmp_psd_if.sv -----
// Channel interfaces of the BMP pixel stream decoder: byte input and pixel output.
// Depends on bmp_psd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bmp_psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  modport source (output valid, data_byte, file_start, input ready);
  modport sink (input valid, data_byte, file_start, output ready);
endinterface

interface bmp_psd_out_if import bmp_psd_pkg::*;;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [11:0] column;
  logic [11:0] target_row;
  logic        has_alpha;
  logic [12:0] image_width;
  logic [12:0] image_height;
  status_t     status;
  logic        last_pixel;
  modport source (output valid, red, green, blue, alpha, column, target_row, has_alpha,
                  image_width, image_height, status, last_pixel, input ready);
  modport sink (input valid, red, green, blue, alpha, column, target_row, has_alpha,
                image_width, image_height, status, last_pixel, output ready);
endinterface
`default_nettype wire

// ----- hdl/bmp_psd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bmp_psd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bmp_pixel_stream_decoder.sv -----
// BMP pixel stream decoder: file bytes in, RGBA pixels out; one byte is accepted per cycle
// while the pipeline has room. A result passes the s1 stage (palette RAM read) and then
// the output register before it is offered.
// The input keeps accepting while a result waits in the output register, until a second
// result is pending. Reset is synchronous; palette valid flags clear at once, no clearing pass.
// Depends on bmp_psd_pkg, bmp_psd_if and bmp_psd_ram.
`timescale 1ns / 1ps
`default_nettype none
module bmp_pixel_stream_decoder import bmp_psd_pkg::*; #(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input wire           clk,
  input wire           rst_n,
  bmp_psd_in_if.sink   in_ch,
  bmp_psd_out_if.source out_ch
);
  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {PH_FILE, PH_INFO, PH_DATA, PH_DONE} phase_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] target_row;
    logic        has_alpha;
    logic [12:0] image_width;
    logic [12:0] image_height;
    status_t     status;
    logic        last_pixel;
  } result_t;

  function automatic logic [31:0] put32(logic [31:0] f, logic [1:0] k, logic [7:0] b);
    logic [31:0] r;
    r = f;
    r[k*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [23:0] put24(logic [23:0] f, logic [1:0] k, logic [7:0] b);
    logic [23:0] r;
    r = f;
    case (k)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r = f;
    endcase
    return r;
  endfunction

  // Parser state.
  phase_t       phase_r, phase_nxt;
  logic [31:0]  pos_r, pos_nxt;
  logic [15:0]  magic_r, magic_nxt;
  logic [31:0]  poff_r, poff_nxt;
  logic [31:0]  isize_r, isize_nxt;
  logic [31:0]  width_r, width_nxt;
  logic [31:0]  height_r, height_nxt;
  logic [15:0]  bpp_r, bpp_nxt;
  logic [31:0]  comp_r, comp_nxt;
  logic [31:0]  ncol_r, ncol_nxt;
  logic [31:0]  abs_h_r, abs_h_nxt;
  logic [31:0]  rowlen_r, rowlen_nxt;
  logic [32:0]  prod_r;
  logic [31:0]  rbc_r, rbc_nxt;
  logic [1:0]   k3_r, k3_nxt;
  logic [23:0]  pixb_r, pixb_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [23:0]  asm_r, asm_nxt;
  logic [PALETTE_DEPTH-1:0] pvalid_r, pvalid_nxt;

  // Pipeline: s1 lines up with the palette read data, then the output register.
  logic         s1_v_r, s1_v_nxt;
  result_t      s1_r, s1_nxt;
  logic         s1_pal_r, s1_pal_nxt;
  logic         s1_ok_r, s1_ok_nxt;
  logic         s1_fwd_r, s1_fwd_nxt;
  logic [23:0]  s1_fdat_r, s1_fdat_nxt;
  logic         out_v_r, out_v_nxt;
  result_t      out_r, out_nxt;

  logic         in_fire, s1_adv;
  logic         pal_we;
  logic [AW-1:0] pal_waddr;
  logic [23:0]  pal_rdata;
  logic [7:0]   b;

  // Current values after a file start has cleared everything.
  phase_t       c_phase;
  logic [31:0]  c_pos, c_poff, c_isize, c_width, c_height, c_comp, c_ncol, c_abs_h;
  logic [31:0]  c_rowlen, c_rbc;
  logic [15:0]  c_magic, c_bpp;
  logic [1:0]   c_k3;
  logic [23:0]  c_pixb, c_asm;
  logic [CW-1:0] c_col;
  logic [RW-1:0] c_row;

  logic         res_v, res_pal, res_ok;
  result_t      res;
  logic [32:0]  pal_start, pal_off;
  logic [31:0]  ncolors;
  logic [30:0]  pal_idx;
  logic [31:0]  abs_calc;
  logic [33:0]  pad_sum;
  logic [31:0]  padded;
  logic         top_down, emit, is_last;
  logic [7:0]   pr, pg, pb, pa;
  logic [1:0]   kk;
  logic [32:0]  rbc_inc;
  logic [31:0]  trow;
  logic [23:0]  pal_rgb;

  assign b        = in_ch.data_byte;
  assign s1_adv   = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    c_phase  = in_ch.file_start ? PH_FILE : phase_r;
    c_pos    = in_ch.file_start ? '0 : pos_r;
    c_magic  = in_ch.file_start ? '0 : magic_r;
    c_poff   = in_ch.file_start ? '0 : poff_r;
    c_isize  = in_ch.file_start ? '0 : isize_r;
    c_width  = in_ch.file_start ? '0 : width_r;
    c_height = in_ch.file_start ? '0 : height_r;
    c_bpp    = in_ch.file_start ? '0 : bpp_r;
    c_comp   = in_ch.file_start ? '0 : comp_r;
    c_ncol   = in_ch.file_start ? '0 : ncol_r;
    c_abs_h  = in_ch.file_start ? '0 : abs_h_r;
    c_rowlen = in_ch.file_start ? '0 : rowlen_r;
    c_rbc    = in_ch.file_start ? '0 : rbc_r;
    c_k3     = in_ch.file_start ? '0 : k3_r;
    c_pixb   = in_ch.file_start ? '0 : pixb_r;
    c_col    = in_ch.file_start ? '0 : col_r;
    c_row    = in_ch.file_start ? '0 : row_r;
    c_asm    = in_ch.file_start ? '0 : asm_r;

    phase_nxt = c_phase;
    magic_nxt = c_magic;
    poff_nxt = c_poff;
    isize_nxt = c_isize;
    width_nxt = c_width;
    height_nxt = c_height;
    bpp_nxt = c_bpp;
    comp_nxt = c_comp;
    ncol_nxt = c_ncol;
    abs_h_nxt = c_abs_h;
    rowlen_nxt = c_rowlen;
    rbc_nxt = c_rbc;
    k3_nxt = c_k3;
    pixb_nxt = c_pixb;
    col_nxt = c_col;
    row_nxt = c_row;
    asm_nxt = c_asm;
    pvalid_nxt = in_ch.file_start ? '0 : pvalid_r;
    pos_nxt = (c_pos == 32'hFFFF_FFFF) ? c_pos : c_pos + 32'd1;

    res_v = 1'b0;
    res_pal = 1'b0;
    pr = '0; pg = '0; pb = '0; pa = '0;
    trow = '0;
    is_last = 1'b0;
    emit = 1'b0;
    kk = '0;
    pal_we = 1'b0;
    pal_waddr = '0;
    top_down = c_height[31];
    abs_calc = top_down ? (32'd0 - c_height) : c_height;
    pad_sum = {1'b0, prod_r} + 34'd31;
    padded = {1'b0, pad_sum[33:5], 2'b00};
    pal_start = 33'd14 + {1'b0, c_isize};
    pal_off = {1'b0, c_pos} - pal_start;
    pal_idx = pal_off[32:2];
    ncolors = (c_ncol != 32'd0) ? c_ncol : (32'd1 << c_bpp[3:0]);
    rbc_inc = {1'b0, c_rbc} + 33'd1;
    res = '0;
    res.status = ST_PIXEL;

    case (c_phase)
      PH_FILE: begin
        if (c_pos < 32'd2) begin
          magic_nxt = c_pos[0] ? {b, c_magic[7:0]} : {c_magic[15:8], b};
        end else if (c_pos >= 32'd10 && c_pos <= 32'd13) begin
          poff_nxt = put32(c_poff, c_pos[1:0] - 2'd2, b);
        end
        if (c_pos == 32'd13) begin
          if (magic_nxt != BMP_MAGIC) begin
            phase_nxt = PH_DONE;
            res_v = 1'b1;
            res.status = ST_BAD_MAGIC;
          end else begin
            phase_nxt = PH_INFO;
          end
        end
      end
      PH_INFO: begin
        if (c_pos >= 32'd14 && c_pos <= 32'd17) begin
          isize_nxt = put32(c_isize, c_pos[1:0] - 2'd2, b);
        end else if (c_pos >= 32'd18 && c_pos <= 32'd21) begin
          width_nxt = put32(c_width, c_pos[1:0] - 2'd2, b);
        end else if (c_pos >= 32'd22 && c_pos <= 32'd25) begin
          height_nxt = put32(c_height, c_pos[1:0] - 2'd2, b);
        end else if (c_pos >= 32'd28 && c_pos <= 32'd29) begin
          bpp_nxt = c_pos[0] ? {b, c_bpp[7:0]} : {c_bpp[15:8], b};
        end else if (c_pos >= 32'd30 && c_pos <= 32'd33) begin
          comp_nxt = put32(c_comp, c_pos[1:0] - 2'd2, b);
        end else if (c_pos >= 32'd46 && c_pos <= 32'd49) begin
          ncol_nxt = put32(c_ncol, c_pos[1:0] - 2'd2, b);
        end
        if (c_pos == 32'd53) begin
          abs_h_nxt = abs_calc;
          if (c_comp != COMP_RGB && c_comp != COMP_BITFIELDS) begin
            phase_nxt = PH_DONE;
            res_v = 1'b1;
            res.status = ST_BAD_COMP;
          end else if (c_width[31] || c_width > 32'(MAX_WIDTH) ||
                       abs_calc > 32'(MAX_HEIGHT)) begin
            phase_nxt = PH_DONE;
            res_v = 1'b1;
            res.status = ST_TOO_LARGE;
          end else if (c_width == 32'd0 || abs_calc == 32'd0) begin
            phase_nxt = PH_DONE;
          end else begin
            rowlen_nxt = (padded > c_width) ? padded : c_width;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        // Palette capture: the entry is assembled byte by byte and written again with each byte.
        if (c_bpp <= 16'd8 && {1'b0, c_pos} >= pal_start && {1'b0, pal_idx} < ncolors &&
            pal_idx < 31'(PALETTE_DEPTH) && pal_off[1:0] != 2'd3) begin
          asm_nxt = (pal_off[1:0] == 2'd0) ? {16'b0, b} : put24(c_asm, pal_off[1:0], b);
          pal_we = 1'b1;
          pal_waddr = pal_idx[AW-1:0];
          pvalid_nxt[pal_idx[AW-1:0]] = 1'b1;
        end
        if (c_pos >= c_poff) begin
          pa = 8'd255;
          if (c_bpp == 16'd24) begin
            kk = c_k3;
            pixb_nxt = put24(c_pixb, kk, b);
            if (kk == 2'd2) begin
              emit = 1'b1;
              pb = c_pixb[7:0];
              pg = c_pixb[15:8];
              pr = b;
            end
          end else if (c_bpp == 16'd32) begin
            kk = c_rbc[1:0];
            if (kk != 2'd3) begin
              pixb_nxt = put24(c_pixb, kk, b);
            end else begin
              emit = 1'b1;
              pb = c_pixb[7:0];
              pg = c_pixb[15:8];
              pr = c_pixb[23:16];
              pa = b;
            end
          end else if (c_bpp == 16'd8) begin
            emit = 1'b1;
            res_pal = 1'b1;
          end else begin
            emit = 1'b1;
          end
          if (emit && 32'(c_col) < c_width) begin
            trow = top_down ? 32'(c_row) : (c_abs_h - 32'd1 - 32'(c_row));
            is_last = (32'(c_col) == c_width - 32'd1) && (32'(c_row) == c_abs_h - 32'd1);
            res_v = 1'b1;
            res.red = pr;
            res.green = pg;
            res.blue = pb;
            res.alpha = pa;
            res.column = 12'(c_col);
            res.target_row = trow[11:0];
            res.last_pixel = is_last;
            col_nxt = c_col + CW'(1);
            if (is_last) begin
              phase_nxt = PH_DONE;
            end
          end
          k3_nxt = (c_k3 == 2'd2) ? 2'd0 : c_k3 + 2'd1;
          rbc_nxt = rbc_inc[31:0];
          if (rbc_inc >= {1'b0, c_rowlen}) begin
            rbc_nxt = '0;
            k3_nxt = '0;
            col_nxt = '0;
            row_nxt = c_row + RW'(1);
            if (32'(c_row) + 32'd1 >= c_abs_h) begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.has_alpha = (c_bpp >= 16'd32);
    res.image_width = c_width[12:0];
    res.image_height = abs_h_nxt[12:0];
    res_ok = pvalid_r[b[AW-1:0]] && !in_ch.file_start;
    if (32'(b) >= 32'(PALETTE_DEPTH)) begin
      res_ok = 1'b0;
    end
  end

  // Second stage: palette data merged in, with forwarding of a same-cycle write.
  always_comb begin
    s1_v_nxt = s1_v_r;
    s1_nxt = s1_r;
    s1_pal_nxt = s1_pal_r;
    s1_ok_nxt = s1_ok_r;
    s1_fwd_nxt = s1_fwd_r;
    s1_fdat_nxt = s1_fdat_r;
    if (in_fire) begin
      s1_v_nxt = res_v;
      s1_nxt = res;
      s1_pal_nxt = res_pal;
      s1_fwd_nxt = pal_we && (pal_waddr == b[AW-1:0]) &&
                   (32'(b) < 32'(PALETTE_DEPTH));
      s1_ok_nxt = res_ok || s1_fwd_nxt;
      s1_fdat_nxt = asm_nxt;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end

    pal_rgb = s1_fwd_r ? s1_fdat_r : pal_rdata;
    if (!s1_ok_r) begin
      pal_rgb = '0;
    end
    out_v_nxt = out_v_r;
    out_nxt = out_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
      out_nxt = s1_r;
      if (s1_pal_r) begin
        out_nxt.blue = pal_rgb[7:0];
        out_nxt.green = pal_rgb[15:8];
        out_nxt.red = pal_rgb[23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 33'(width_r[16:0] * bpp_r);
    s1_r <= s1_nxt;
    s1_pal_r <= s1_pal_nxt;
    s1_ok_r <= s1_ok_nxt;
    s1_fwd_r <= s1_fwd_nxt;
    s1_fdat_r <= s1_fdat_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      phase_r <= PH_FILE;
      pos_r <= '0;
      magic_r <= '0;
      poff_r <= '0;
      isize_r <= '0;
      width_r <= '0;
      height_r <= '0;
      bpp_r <= '0;
      comp_r <= '0;
      ncol_r <= '0;
      abs_h_r <= '0;
      rowlen_r <= '0;
      rbc_r <= '0;
      k3_r <= '0;
      pixb_r <= '0;
      col_r <= '0;
      row_r <= '0;
      asm_r <= '0;
      pvalid_r <= '0;
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        pos_r <= pos_nxt;
        magic_r <= magic_nxt;
        poff_r <= poff_nxt;
        isize_r <= isize_nxt;
        width_r <= width_nxt;
        height_r <= height_nxt;
        bpp_r <= bpp_nxt;
        comp_r <= comp_nxt;
        ncol_r <= ncol_nxt;
        abs_h_r <= abs_h_nxt;
        rowlen_r <= rowlen_nxt;
        rbc_r <= rbc_nxt;
        k3_r <= k3_nxt;
        pixb_r <= pixb_nxt;
        col_r <= col_nxt;
        row_r <= row_nxt;
        asm_r <= asm_nxt;
        pvalid_r <= pvalid_nxt;
      end
    end
  end

  bmp_psd_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (in_fire && pal_we),
    .waddr (pal_waddr),
    .wdata (asm_nxt),
    .re    (in_fire),
    .raddr (b[AW-1:0]),
    .rdata (pal_rdata)
  );

  assign out_ch.valid        = out_v_r;
  assign out_ch.red          = out_r.red;
  assign out_ch.green        = out_r.green;
  assign out_ch.blue         = out_r.blue;
  assign out_ch.alpha        = out_r.alpha;
  assign out_ch.column       = out_r.column;
  assign out_ch.target_row   = out_r.target_row;
  assign out_ch.has_alpha    = out_r.has_alpha;
  assign out_ch.image_width  = out_r.image_width;
  assign out_ch.image_height = out_r.image_height;
  assign out_ch.status       = out_r.status;
  assign out_ch.last_pixel   = out_r.last_pixel;
endmodule
`default_nettype wire

// ----- hdl/bmp_psd_checker.sv -----
// Port-level checker for the BMP pixel stream decoder, bound to the top level.
// Depends on bmp_psd_pkg and bmp_pixel_stream_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_pixel_stream_decoder_assert.svh"
module bmp_psd_checker import bmp_psd_pkg::*; (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [7:0]  out_red,
  input wire [7:0]  out_green,
  input wire [7:0]  out_blue,
  input wire [7:0]  out_alpha,
  input wire [11:0] out_column,
  input wire        out_has_alpha,
  input wire [12:0] out_image_width,
  input wire [1:0]  out_status,
  input wire        out_last_pixel
);
  logic [12:0] width_m1;
  assign width_m1 = out_image_width - 13'd1;

  `BPSD_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_status), "stalled item changed")
  `BPSD_ASSERT(a_err_zero, out_valid && out_status != ST_PIXEL |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0 && !out_last_pixel, "error item carries pixel data")
  `BPSD_ASSERT(a_last_col, out_valid && out_last_pixel |-> out_status == ST_PIXEL && out_column == width_m1[11:0], "last pixel not at row end")
  `BPSD_ASSERT(a_opaque, out_valid && out_status == ST_PIXEL && !out_has_alpha |-> out_alpha == 8'd255, "opaque pixel with alpha")
endmodule

bind bmp_pixel_stream_decoder bmp_psd_checker u_bmp_psd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_red         (out_ch.red),
  .out_green       (out_ch.green),
  .out_blue        (out_ch.blue),
  .out_alpha       (out_ch.alpha),
  .out_column      (out_ch.column),
  .out_has_alpha   (out_ch.has_alpha),
  .out_image_width (out_ch.image_width),
  .out_status      (out_ch.status),
  .out_last_pixel  (out_ch.last_pixel)
);
`default_nettype wire

// ----- bench/tb_bmp_pixel_stream_decoder.sv -----
// Testbench of the BMP pixel stream decoder: streams generated BMP files byte by byte
// and checks every pixel and error result against a built-in predictor.
// Depends on bmp_psd_pkg, bmp_psd_if and the decoder RTL.
`timescale 1ns / 1ps
module tb_bmp_pixel_stream_decoder;
  import bmp_psd_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] target_row;
    logic        has_alpha;
    logic [12:0] image_width;
    logic [12:0] image_height;
    status_t     status;
    logic        last_pixel;
  } pixel_t;

  typedef enum logic [1:0] {PH_FILE, PH_INFO, PH_DATA, PH_DONE} phase_t;

  class pixel_scoreboard;
    pixel_t      pending_px[$];
    int          errors;
    logic [31:0] pos, pix_off, info_sz, hw, hh, bpp, comp, ncol, magic, abs_h, pix_acc;
    logic [23:0] pal[256];
    longint      row_bytes, row_len;
    logic [31:0] col, row;
    phase_t      phase;

    function void clear();
      pos = 0; pix_off = 0; info_sz = 0; hw = 0; hh = 0; bpp = 0; comp = 0; ncol = 0;
      magic = 0; abs_h = 0; pix_acc = 0; row_bytes = 0; row_len = 0; col = 0; row = 0;
      phase = PH_FILE;
      for (int i = 0; i < 256; i++) pal[i] = '0;
    endfunction

    function void push(logic [7:0] r, g, b, a, logic [31:0] c, trow, status_t st,
                       logic last);
      pixel_t p;
      p.red = r; p.green = g; p.blue = b; p.alpha = a;
      p.column = c[11:0]; p.target_row = trow[11:0];
      p.has_alpha = (bpp >= 32);
      p.image_width = hw[12:0]; p.image_height = abs_h[12:0];
      p.status = st; p.last_pixel = last;
      pending_px.push_back(p);
    endfunction

    function void end_of_info();
      longint padded;
      abs_h = hh[31] ? (32'd0 - hh) : hh;
      if (comp != COMP_RGB && comp != COMP_BITFIELDS) begin
        phase = PH_DONE;
        push(0, 0, 0, 0, 0, 0, ST_BAD_COMP, 0);
      end else if (hw[31] || hw > MAX_WIDTH_DEF || abs_h > MAX_HEIGHT_DEF) begin
        phase = PH_DONE;
        push(0, 0, 0, 0, 0, 0, ST_TOO_LARGE, 0);
      end else if (hw == 0 || abs_h == 0) begin
        phase = PH_DONE;
      end else begin
        padded = ((longint'(hw) * longint'(bpp) + 31) / 32) * 4;
        row_len = (padded > longint'(hw)) ? padded : longint'(hw);
        phase = PH_DATA;
      end
    endfunction

    function void take_palette(logic [7:0] b);
      longint start, ncolors, cap, off;
      start = 14 + longint'(info_sz);
      if (bpp > 8 || longint'(pos) < start) return;
      ncolors = (ncol != 0) ? longint'(ncol) : (longint'(1) << bpp);
      cap = (ncolors < PALETTE_DEPTH_DEF) ? ncolors : PALETTE_DEPTH_DEF;
      off = longint'(pos) - start;
      if (off / 4 < cap && off % 4 != 3) pal[(off / 4) % 256][(off % 4) * 8 +: 8] = b;
    endfunction

    function void decode_byte(logic [7:0] b);
      logic        emit, last;
      logic [7:0]  r, g, bl, a;
      logic [23:0] e;
      int          k;
      logic [31:0] trow;
      emit = 0; r = 0; g = 0; bl = 0; a = 8'd255;
      if (bpp == 24) begin
        k = row_bytes % 3;
        pix_acc[k*8 +: 8] = b;
        if (k == 2) begin
          emit = 1; bl = pix_acc[7:0]; g = pix_acc[15:8]; r = b;
        end
      end else if (bpp == 32) begin
        k = row_bytes % 4;
        if (k < 3) pix_acc[k*8 +: 8] = b;
        else begin
          emit = 1; bl = pix_acc[7:0]; g = pix_acc[15:8]; r = pix_acc[23:16]; a = b;
        end
      end else if (bpp == 8) begin
        e = pal[b];
        emit = 1; bl = e[7:0]; g = e[15:8]; r = e[23:16];
      end else begin
        emit = 1;
      end
      if (emit && col < hw) begin
        trow = hh[31] ? row : (abs_h - 1 - row);
        last = (col == hw - 1) && (row == abs_h - 1);
        push(r, g, bl, a, col, trow, ST_PIXEL, last);
        col++;
        if (last) phase = PH_DONE;
      end
      row_bytes++;
      if (row_bytes >= row_len) begin
        row_bytes = 0; col = 0; row++;
        if (row >= abs_h) phase = PH_DONE;
      end
    endfunction

    // Called for every accepted input item.
    function void note_byte(logic [7:0] b, logic fs);
      if (fs) clear();
      case (phase)
        PH_FILE: begin
          if (pos < 2) magic[pos*8 +: 8] = b;
          else if (pos >= 10 && pos <= 13) pix_off[(pos-10)*8 +: 8] = b;
          if (pos == 13) begin
            if (magic[15:0] != BMP_MAGIC) begin
              phase = PH_DONE;
              push(0, 0, 0, 0, 0, 0, ST_BAD_MAGIC, 0);
            end else phase = PH_INFO;
          end
        end
        PH_INFO: begin
          if (pos >= 14 && pos <= 17) info_sz[(pos-14)*8 +: 8] = b;
          else if (pos >= 18 && pos <= 21) hw[(pos-18)*8 +: 8] = b;
          else if (pos >= 22 && pos <= 25) hh[(pos-22)*8 +: 8] = b;
          else if (pos >= 28 && pos <= 29) bpp[(pos-28)*8 +: 8] = b;
          else if (pos >= 30 && pos <= 33) comp[(pos-30)*8 +: 8] = b;
          else if (pos >= 46 && pos <= 49) ncol[(pos-46)*8 +: 8] = b;
          if (pos == 53) end_of_info();
        end
        PH_DATA: begin
          take_palette(b);
          if (pos >= pix_off) decode_byte(b);
        end
        default: ;
      endcase
      if (pos != 32'hFFFF_FFFF) pos++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (pending_px.size() == 0) begin
        $error("unexpected result item: status %0d", got.status);
        errors++;
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.red != exp_px.red) begin
        $error("red: expected %0d, got %0d", exp_px.red, got.red); errors++;
      end
      if (got.green != exp_px.green) begin
        $error("green: expected %0d, got %0d", exp_px.green, got.green); errors++;
      end
      if (got.blue != exp_px.blue) begin
        $error("blue: expected %0d, got %0d", exp_px.blue, got.blue); errors++;
      end
      if (got.alpha != exp_px.alpha) begin
        $error("alpha: expected %0d, got %0d", exp_px.alpha, got.alpha); errors++;
      end
      if (got.column != exp_px.column) begin
        $error("column: expected %0d, got %0d", exp_px.column, got.column); errors++;
      end
      if (got.target_row != exp_px.target_row) begin
        $error("target_row: expected %0d, got %0d", exp_px.target_row, got.target_row);
        errors++;
      end
      if (got.has_alpha != exp_px.has_alpha) begin
        $error("has_alpha: expected %0d, got %0d", exp_px.has_alpha, got.has_alpha);
        errors++;
      end
      if (got.image_width != exp_px.image_width) begin
        $error("image_width: expected %0d, got %0d", exp_px.image_width, got.image_width);
        errors++;
      end
      if (got.image_height != exp_px.image_height) begin
        $error("image_height: expected %0d, got %0d", exp_px.image_height,
               got.image_height);
        errors++;
      end
      if (got.status != exp_px.status) begin
        $error("status: expected %0d, got %0d", exp_px.status, got.status); errors++;
      end
      if (got.last_pixel != exp_px.last_pixel) begin
        $error("last_pixel: expected %0d, got %0d", exp_px.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  bmp_psd_in_if  in_ch ();
  bmp_psd_out_if out_ch ();

  bmp_pixel_stream_decoder dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  pixel_scoreboard sb = new();
  logic [7:0] file_bytes[$];
  logic       quiet = 0;
  int         bytes_sent = 0;
  int         stall_left = 0;
  int         idle_cycles = 0;

  initial begin
    in_ch.valid = 0; in_ch.data_byte = 0; in_ch.file_start = 0;
    out_ch.ready = 0;
    sb.clear();
    sb.errors = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.file_start);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pixel('{out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha, out_ch.column,
                       out_ch.target_row, out_ch.has_alpha, out_ch.image_width,
                       out_ch.image_height, out_ch.status, out_ch.last_pixel});
  end

  // Result side backpressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ch.ready <= 0;
    end else out_ch.ready <= 1;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data_byte <= b;
    in_ch.file_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
  endtask

  // Builds a file in file_bytes. A negative offset shift puts the pixel offset
  // before the end of the palette, so palette bytes double as pixel data.
  task automatic make_file(input logic [15:0] magic, input logic [31:0] w, h,
                           input logic [15:0] bpp, input logic [31:0] comp, colors,
                           input int off_shift, input int tail);
    logic [7:0]  hd[54];
    logic [31:0] poff, ah;
    longint      npal, padded, rl, ndata;
    for (int i = 0; i < 54; i++) hd[i] = $urandom;
    npal = 0;
    if (bpp <= 8) npal = (colors != 0) ? longint'(colors) : (longint'(1) << bpp);
    if (npal > 256) npal = 256;
    poff = 54 + 4 * npal + off_shift;
    hd[0] = magic[7:0]; hd[1] = magic[15:8];
    for (int k = 0; k < 4; k++) begin
      hd[10+k] = poff[k*8 +: 8];
      hd[14+k] = (k == 0) ? 8'd40 : 8'd0;
      hd[18+k] = w[k*8 +: 8];
      hd[22+k] = h[k*8 +: 8];
      hd[30+k] = comp[k*8 +: 8];
      hd[46+k] = colors[k*8 +: 8];
    end
    hd[28] = bpp[7:0]; hd[29] = bpp[15:8];
    file_bytes.delete();
    foreach (hd[i]) file_bytes.push_back(hd[i]);
    for (longint i = 0; i < 4 * npal + (off_shift > 0 ? off_shift : 0); i++)
      file_bytes.push_back($urandom);
    ah = h[31] ? (32'd0 - h) : h;
    ndata = 0;
    if (!w[31] && w <= MAX_WIDTH_DEF && ah <= MAX_HEIGHT_DEF) begin
      padded = ((longint'(w) * longint'(bpp) + 31) / 32) * 4;
      rl = (padded > longint'(w)) ? padded : longint'(w);
      ndata = rl * ah;
    end
    for (longint i = 0; i < ndata + tail; i++)
      file_bytes.push_back(bpp == 8 ? 8'($urandom_range(0, npal + 2)) : 8'($urandom));
  endtask

  task automatic random_file();
    logic [15:0] bpp;
    logic [31:0] w, h, comp, colors;
    int kind;
    kind = $urandom_range(0, 5);
    case (kind)
      0: bpp = 24;
      1: bpp = 32;
      2, 3: bpp = 8;
      4: bpp = 16'($urandom_range(1, 4));
      default: bpp = 16;
    endcase
    w = $urandom_range(1, 7);
    h = $urandom_range(1, 4);
    if ($urandom_range(0, 1)) h = 32'd0 - h;
    comp = $urandom_range(0, 1) ? COMP_RGB : COMP_BITFIELDS;
    colors = (bpp <= 8) ? $urandom_range(1, 12) : $urandom;
    if ($urandom_range(0, 15) == 0) comp = $urandom_range(1, 2);
    if ($urandom_range(0, 19) == 0) w = $urandom_range(MAX_WIDTH_DEF + 1, 32'hFFFF_FFFF);
    make_file($urandom_range(0, 19) == 0 ? 16'($urandom) : BMP_MAGIC, w, h, bpp, comp,
              colors, $urandom_range(0, 7) == 0 ? -$urandom_range(1, 30)
                                                : $urandom_range(0, 3),
              $urandom_range(0, 5) == 0 ? $urandom_range(1, 6) : 0);
  endtask

  initial begin
    bit paused;
    paused = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed files: depths 1, 8, 16, 24 and 32, both row orders, each error and the empty image.
    make_file(BMP_MAGIC, 3, 2, 24, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 2, -3, 24, COMP_BITFIELDS, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 2, 2, 32, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 3, 2, 8, COMP_RGB, 4, 0, 0); send_file();
    make_file(BMP_MAGIC, 4, 1, 8, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 5, 2, 1, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 3, -2, 16, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 3, 2, 8, COMP_RGB, 6, -20, 0); send_file();
    make_file(BMP_MAGIC, 1, 1, 24, COMP_RGB, 0, 3, 5); send_file();
    make_file(BMP_MAGIC, 2, 2, 24, 32'd1, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 2, 2, 32, 32'hFFFF_FFFF, 0, 0, 0); send_file();
    make_file(16'h424D, 2, 2, 24, COMP_RGB, 0, 0, 0); send_file();
    make_file(16'hFFFF, 2, 2, 32, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, MAX_WIDTH_DEF + 1, 1, 24, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, MAX_WIDTH_DEF, MAX_HEIGHT_DEF + 1, 32, COMP_RGB, 0, 0, 0);
    send_file();
    make_file(BMP_MAGIC, 2, 32'd0 - (MAX_HEIGHT_DEF + 1), 24, COMP_RGB, 0, 0, 0);
    send_file();
    make_file(BMP_MAGIC, 32'h8000_0000, 1, 24, COMP_RGB, 0, 0, 0); send_file();
    make_file(BMP_MAGIC, 0, 3, 24, COMP_RGB, 0, 0, 4); send_file();
    make_file(BMP_MAGIC, 3, 0, 8, COMP_RGB, 2, 0, 4); send_file();
    for (int i = 0; i < 12; i++) send_byte($urandom, $urandom_range(0, 3) == 0);
    // Random part: mostly well-formed files, some broken ones and noise.
    while (bytes_sent < 1650) begin
      if (!paused && bytes_sent > 800) begin
        paused = 1;
        in_ch.valid <= 0;
        @(posedge clk);
        while (sb.pending_px.size() != 0) @(posedge clk);
      end
      if (bytes_sent > 1350) quiet = 1;
      if ($urandom_range(0, 11) == 0) begin
        for (int i = 0; i < 10; i++) send_byte($urandom, $urandom_range(0, 3) == 0);
      end else begin
        random_file();
        send_file();
      end
    end
    in_ch.valid <= 0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_px.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
